[design/bcnd_pkg.sv]
// Package for the base32 check-nibble decoder: word types, status codes,
// the symbol alphabet and its lookup function. Depends on nothing.
package bcnd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADCHAR  = 2'd1,
        ST_BADCHECK = 2'd2,
        ST_SHORT    = 2'd3
    } status_t;

    // Input word: one character of the encoded message.
    typedef struct packed {
        logic [7:0] text_char;
        logic       message_last;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [7:0] data_byte;
        status_t    status;
        logic       message_end;
    } out_word_t;

    // Results pushed into the queue by one character: none, one or two.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } push_t;

    // Outcome of an alphabet lookup.
    typedef struct packed {
        logic       hit;
        logic [4:0] value;
    } symbol_t;

    localparam int unsigned SYMBOLS = 32;

    localparam logic [7:0] ALPHABET [SYMBOLS] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
        8'h6b, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73,
        8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h30,
        8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
    };

    // Map a character to its index in the alphabet; hit is low when unknown.
    function automatic symbol_t symbol_of(input logic [7:0] ch);
        symbol_t res;
        res = '0;
        for (int i = 0; i < SYMBOLS; i++) begin
            if (ALPHABET[i] == ch) begin
                res.hit   = 1'b1;
                res.value = 5'(i);
            end
        end
        return res;
    endfunction

endpackage

[design/bcnd_group_unit.sv]
// Input register, group assembly and check logic of the base32 decoder.
// Depends on bcnd_pkg; pushes its results into bcnd_result_queue.
module bcnd_group_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bcnd_pkg::in_word_t s_data,
    input  logic             room,
    output bcnd_pkg::push_t  push
);
    import bcnd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    in_word_t    in_word_reg;
    logic [1:0]  count_reg, count_next;
    logic [14:0] partial_reg, partial_next;
    logic        discard_reg, discard_next;
    logic        take;
    symbol_t     sym;
    logic [19:0] group;
    logic [3:0]  check;

    // The held word is processed once the queue has space for two results.
    assign take    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    // Decode the held character against the current group.
    assign sym   = symbol_of(in_word_reg.text_char);
    assign group = {partial_reg, sym.value};
    assign check = group[3:0] ^ group[7:4] ^ group[11:8] ^ group[15:12] ^ group[19:16];

    always_comb begin
        count_next   = count_reg;
        partial_next = partial_reg;
        discard_next = discard_reg;
        push         = '0;
        if (take) begin
            if (discard_reg) begin
                if (in_word_reg.message_last) begin
                    discard_next = 1'b0;
                end
            end else if (!sym.hit) begin
                count_next   = '0;
                partial_next = '0;
                discard_next = !in_word_reg.message_last;
                push.count   = 2'd1;
                push.first   = '{data_byte: 8'h00, status: ST_BADCHAR, message_end: 1'b1};
            end else if (count_reg != 2'd3) begin
                if (in_word_reg.message_last) begin
                    count_next   = '0;
                    partial_next = '0;
                    push.count   = 2'd1;
                    push.first   = '{data_byte: 8'h00, status: ST_SHORT, message_end: 1'b1};
                end else begin
                    count_next   = count_reg + 2'd1;
                    partial_next = group[14:0];
                end
            end else begin
                count_next   = '0;
                partial_next = '0;
                if (check != 4'h0) begin
                    discard_next = !in_word_reg.message_last;
                    push.count   = 2'd1;
                    push.first   = '{data_byte: 8'h00, status: ST_BADCHECK,
                                     message_end: 1'b1};
                end else begin
                    push.count  = 2'd2;
                    push.first  = '{data_byte: group[19:12], status: ST_OK,
                                    message_end: 1'b0};
                    push.second = '{data_byte: group[11:4], status: ST_OK,
                                    message_end: in_word_reg.message_last};
                end
            end
        end
    end

    // Control state and group registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            partial_reg  <= '0;
            discard_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            partial_reg  <= partial_next;
            discard_reg  <= discard_next;
        end
    end

    // Input word register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

endmodule

[design/bcnd_result_queue.sv]
// Four-entry result queue taking up to two words per cycle and giving one.
// Depends on bcnd_pkg.
module bcnd_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  bcnd_pkg::push_t   push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output bcnd_pkg::out_word_t m_data
);
    import bcnd_pkg::*;

    out_word_t  entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;
    logic [1:0] wr_ptr_inc;
    logic       pop;

    assign room       = fill_reg <= 3'd2;
    assign m_valid    = fill_reg != 3'd0;
    assign m_data     = entry_reg[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign wr_ptr_inc = wr_ptr_reg + 2'd1;

    // Pointer and fill arithmetic.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        fill_next   = fill_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage: the first word at the write pointer, the second after it.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

[design/base32_check_nibble_decoder.sv]
// Top level of the base32 check-nibble decoder.
// Depends on bcnd_pkg, bcnd_group_unit and bcnd_result_queue.
//
//   Channel | Direction | Word        | Fields
//   s_      | in        | in_word_t   | text_char, message_last
//   m_      | out       | out_word_t  | data_byte, status, message_end
//
// One character is accepted per cycle while the queue has space for two
// results; it is registered, decoded in one pass once the queue has room,
// and its zero, one or two results enter a four-entry queue, from whose
// registers the first result is offered. A held character waits only while
// the queue lacks space for two results. Results leave one per cycle while
// m_ready is high; reset (aresetn low, synchronous) empties the queue and
// clears the group in progress and the discard flag.
module base32_check_nibble_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bcnd_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bcnd_pkg::out_word_t m_data
);
    import bcnd_pkg::*;

    push_t push;
    logic  room;

    // Group assembly and checking.
    bcnd_group_unit u_group (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .room    (room),
        .push    (push)
    );

    // Result buffering towards the output channel.
    bcnd_result_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
